FILE: design/point_and_shoot_steering_unit_assert.svh
// ----------------------------------------------------------------------------
// point_and_shoot_steering_unit_assert.svh
// assertion macros used by the steering unit controller
// ----------------------------------------------------------------------------
`ifndef POINT_AND_SHOOT_STEERING_UNIT_ASSERT_SVH
`define POINT_AND_SHOOT_STEERING_UNIT_ASSERT_SVH

// same-cycle implication
`define PSS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("steering unit check failed");

// next-cycle implication
`define PSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("steering unit check failed");

`endif

FILE: design/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg
// shared types, constants and tables of the point-and-shoot steering unit
// ----------------------------------------------------------------------------
package pss_pkg;

  localparam int POS_WIDTH_DEF    = 32;
  localparam int ANGLE_WIDTH_DEF  = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int HEAD_DEG_W = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;
  localparam int TOL_W      = 12;
  localparam int SPEED_W    = 31;

  localparam logic [CFG_IDX_W-1:0] REG_ALIGN_TOL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FINAL_TOL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CRUISE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN    = 2'd3;

  localparam logic [TOL_W-1:0]   ALIGN_TOL_RST = 12'd20;
  localparam logic [TOL_W-1:0]   FINAL_TOL_RST = 12'd41;
  localparam logic [SPEED_W-1:0] CRUISE_RST    = 31'd655360;
  localparam logic [SPEED_W-1:0] MARGIN_RST    = 31'd65536;

  localparam int ATAN_FRAC   = 20;
  localparam int PI_Q20      = 3294199;
  localparam int HALF_PI_Q20 = 1647099;
  localparam int DEG_RAD_Q28 = 4685083;
  localparam int DEG_FRAC    = 28;
  localparam int ATAN_W      = 21;
  localparam int ATAN_IDX_W  = 5;
  localparam int NORM_BITS   = 31;
  localparam int SQ_W        = 62;
  localparam int RAD_W       = 64;

  typedef enum logic [2:0] {
    RES_TURN,
    RES_CRUISE,
    RES_DIST,
    RES_STOP,
    RES_HEAD,
    RES_DONE
  } res_sel_e;

  typedef struct packed {
    logic     in_capture;
    logic     goal_load;
    logic     cordic_init;
    logic     cordic_step;
    logic     target_latch;
    logic     dist_load;
    logic     dist_norm;
    logic     dist_sq_a;
    logic     dist_sq_b;
    logic     sqrt_step;
    logic     dist_final;
    logic     emit;
    res_sel_e res_sel;
    logic     res_last;
    logic     prev_update;
    logic     cmp_margin;
  } cmd_t;

  typedef struct packed {
    logic turn_ok;
    logic final_ok;
    logic grew;
    logic cordic_last;
    logic norm_done;
    logic sqrt_done;
  } status_t;

  // arctangent of 2^-i, 20 fraction bits
  function automatic logic [ATAN_W-1:0] atan_step(input logic [ATAN_IDX_W-1:0] i);
    logic [ATAN_W-1:0] v;
    case (i)
      5'd0: v = 21'd823550;
      5'd1: v = 21'd486170;
      5'd2: v = 21'd256879;
      5'd3: v = 21'd130396;
      5'd4: v = 21'd65451;
      5'd5: v = 21'd32757;
      5'd6: v = 21'd16383;
      default: begin
        if (i <= 5'(ATAN_FRAC)) v = ATAN_W'(1) << (5'(ATAN_FRAC) - i);
        else v = '0;
      end
    endcase
    return v;
  endfunction

endpackage

FILE: design/pss_if.sv
// ----------------------------------------------------------------------------
// pss_in_if / pss_out_if
// valid-ready channels for odometry and goal requests and for twist commands
// ----------------------------------------------------------------------------
interface pss_in_if #(
  parameter int POS_WIDTH   = 32,
  parameter int ANGLE_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic signed [POS_WIDTH-1:0]   pos_x;
  logic signed [POS_WIDTH-1:0]   pos_y;
  logic signed [ANGLE_WIDTH-1:0] yaw;
  logic signed [POS_WIDTH-1:0]   goal_x;
  logic signed [POS_WIDTH-1:0]   goal_y;
  logic signed [10:0]            goal_heading_deg;

  modport source (output valid, kind, pos_x, pos_y, yaw, goal_x, goal_y, goal_heading_deg,
                  input ready);
  modport sink (input valid, kind, pos_x, pos_y, yaw, goal_x, goal_y, goal_heading_deg,
                output ready);
endinterface

interface pss_out_if #(
  parameter int POS_WIDTH   = 32,
  parameter int ANGLE_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [ANGLE_WIDTH-1:0] angular_rate;
  logic [POS_WIDTH-2:0]          linear_speed;
  logic                          last_of_run;
  logic                          motion_finished;

  modport source (output valid, angular_rate, linear_speed, last_of_run, motion_finished,
                  input ready);
  modport sink (input valid, angular_rate, linear_speed, last_of_run, motion_finished,
                output ready);
endinterface

FILE: design/pss_dp.sv
// ----------------------------------------------------------------------------
// pss_dp
// datapath: config registers, cordic bearing, distance root, command register
// ----------------------------------------------------------------------------
module pss_dp #(
  parameter int POS_WIDTH    = 32,
  parameter int ANGLE_WIDTH  = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic signed [POS_WIDTH-1:0]           pos_x_i,
  input  logic signed [POS_WIDTH-1:0]           pos_y_i,
  input  logic signed [ANGLE_WIDTH-1:0]         yaw_i,
  input  logic signed [POS_WIDTH-1:0]           goal_x_i,
  input  logic signed [POS_WIDTH-1:0]           goal_y_i,
  input  logic signed [pss_pkg::HEAD_DEG_W-1:0] goal_heading_deg_i,
  input  logic                                  cfg_we_i,
  input  logic [pss_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [pss_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  pss_pkg::cmd_t                         cmd_i,
  output pss_pkg::status_t                      sts_o,
  output logic signed [ANGLE_WIDTH-1:0]         angular_rate_o,
  output logic [POS_WIDTH-2:0]                  linear_speed_o,
  output logic                                  last_of_run_o,
  output logic                                  motion_finished_o
);
  import pss_pkg::*;

  localparam int FRAC = ANGLE_WIDTH - 4;
  localparam int AXW  = ANGLE_WIDTH + 4;
  localparam int CW   = POS_WIDTH + 4;
  localparam int NW   = POS_WIDTH + 1;
  localparam int ZW   = 24;
  localparam int ZS   = ATAN_FRAC - FRAC;
  localparam int HS   = DEG_FRAC - FRAC;
  localparam int HW   = 36;
  localparam int DW   = POS_WIDTH - 1;
  localparam int SHW  = $clog2(POS_WIDTH + 2);
  localparam int RW   = ((POS_WIDTH > 32) ? POS_WIDTH : 32) + 2;
  localparam int GW   = ((DW > SPEED_W) ? DW : SPEED_W) + 1;
  localparam int CNTW = $clog2(CORDIC_STEPS);
  localparam int PI_A = (PI_Q20 + (2 ** ZS) / 2) >> ZS;

  localparam logic signed [AXW-1:0] PI_W     = AXW'(PI_A);
  localparam logic signed [AXW-1:0] TWO_PI_W = AXW'(2 * PI_A);
  localparam logic signed [ZW-1:0]  HALF_PI  = ZW'(HALF_PI_Q20);
  localparam logic signed [HW-1:0]  DEG_K    = HW'(DEG_RAD_Q28);
  localparam logic [NW-1:0]         DMAX_N   = NW'({DW{1'b1}});
  localparam logic [RW-1:0]         DMAX_R   = RW'({DW{1'b1}});

  function automatic logic signed [AXW-1:0] wrap_f(input logic signed [AXW-1:0] a);
    logic signed [AXW-1:0] v;
    v = a;
    for (int k = 0; k < 3; k++) begin
      if (v > PI_W) v = v - TWO_PI_W;
      else if (v < -PI_W) v = v + TWO_PI_W;
    end
    return v;
  endfunction

  // config
  logic [TOL_W-1:0]   align_q, final_q;
  logic [SPEED_W-1:0] cruise_q, margin_q;

  // algorithm state
  logic signed [POS_WIDTH-1:0]   lx_q, ly_q, gx_q, gy_q;
  logic signed [ANGLE_WIDTH-1:0] yaw_q, bearing_q, heading_q;
  logic [DW-1:0]                 prev_q;

  // working registers
  logic signed [HW-1:0] hprod_q;
  logic signed [CW-1:0] cx_q, cy_q;
  logic signed [ZW-1:0] cz_q;
  logic [CNTW-1:0]      cnt_q;
  logic                 zero_q;
  logic [NW-1:0]        a_q, b_q;
  logic                 sat_q;
  logic [SHW-1:0]       sh_q;
  logic [SQ_W-1:0]      sqa_q;
  logic [RAD_W-1:0]     v_q, r_q, bit_q;
  logic [DW-1:0]        dist_q;

  logic signed [ANGLE_WIDTH-1:0] ang_q;
  logic [DW-1:0]                 lin_q;
  logic                          last_q, fin_q;

  // cordic
  logic signed [NW-1:0]   dx, dy;
  logic signed [CW-1:0]   x0, y0, xs, ys;
  logic signed [ZW-1:0]   z0, at, zr;
  logic                   y_pos;
  logic signed [HW-1:0]   hr;
  logic signed [ANGLE_WIDTH-1:0] bearing_d, heading_d;

  assign dx = NW'(gx_q) - NW'(lx_q);
  assign dy = NW'(gy_q) - NW'(ly_q);

  always_comb begin
    if (dx[NW-1]) begin
      if (!dy[NW-1]) begin
        x0 = CW'(dy);
        y0 = -CW'(dx);
        z0 = HALF_PI;
      end else begin
        x0 = -CW'(dy);
        y0 = CW'(dx);
        z0 = -HALF_PI;
      end
    end else begin
      x0 = CW'(dx);
      y0 = CW'(dy);
      z0 = '0;
    end
  end

  assign xs    = cx_q >>> cnt_q;
  assign ys    = cy_q >>> cnt_q;
  assign at    = ZW'(atan_step(ATAN_IDX_W'(cnt_q)));
  assign y_pos = !cy_q[CW-1] && (cy_q != '0);
  assign zr    = (cz_q + ZW'((2 ** ZS) / 2)) >>> ZS;
  assign hr    = (hprod_q + HW'((2 ** HS) / 2)) >>> HS;

  assign bearing_d = zero_q ? '0 : ANGLE_WIDTH'(wrap_f(AXW'(zr)));
  assign heading_d = ANGLE_WIDTH'(wrap_f(AXW'(hr)));

  // heading errors
  logic signed [AXW-1:0] yaw_w, db, dh;
  logic [AXW-1:0]        mb, mh;

  assign yaw_w = wrap_f(AXW'(yaw_q));
  assign db    = AXW'(bearing_q) - yaw_w;
  assign dh    = AXW'(heading_q) - yaw_w;
  assign mb    = db[AXW-1] ? AXW'(-db) : AXW'(db);
  assign mh    = dh[AXW-1] ? AXW'(-dh) : AXW'(dh);

  // distance
  logic [NW-1:0]    adx, ady;
  logic [30:0]      a31, b31;
  logic [SQ_W-1:0]  sqa_d, sqb_d;
  logic [RAD_W-1:0] trial;
  logic [RW-1:0]    rx;
  logic [GW-1:0]    cmp;

  assign adx   = dx[NW-1] ? NW'(-dx) : NW'(dx);
  assign ady   = dy[NW-1] ? NW'(-dy) : NW'(dy);
  assign a31   = 31'(a_q);
  assign b31   = 31'(b_q);
  assign sqa_d = a31 * a31;
  assign sqb_d = b31 * b31;
  assign trial = r_q + bit_q;
  assign rx    = RW'(r_q) << sh_q;
  assign cmp   = cmd_i.cmp_margin ? (GW'(dist_q) + GW'(margin_q)) : GW'(prev_q);

  assign sts_o.turn_ok     = mb <= AXW'(align_q);
  assign sts_o.final_ok    = mh <= AXW'(final_q);
  assign sts_o.grew        = GW'(dist_q) > cmp;
  assign sts_o.cordic_last = cnt_q == CNTW'(CORDIC_STEPS - 1);
  assign sts_o.norm_done   = ((a_q | b_q) >> NORM_BITS) == '0;
  assign sts_o.sqrt_done   = bit_q == '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      align_q   <= ALIGN_TOL_RST;
      final_q   <= FINAL_TOL_RST;
      cruise_q  <= CRUISE_RST;
      margin_q  <= MARGIN_RST;
      lx_q      <= '0;
      ly_q      <= '0;
      yaw_q     <= '0;
      gx_q      <= '0;
      gy_q      <= '0;
      bearing_q <= '0;
      heading_q <= '0;
      prev_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ALIGN_TOL: align_q  <= TOL_W'(cfg_data_i);
          REG_FINAL_TOL: final_q  <= TOL_W'(cfg_data_i);
          REG_CRUISE:    cruise_q <= cfg_data_i;
          REG_MARGIN:    margin_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.in_capture) begin
        lx_q  <= pos_x_i;
        ly_q  <= pos_y_i;
        yaw_q <= yaw_i;
      end
      if (cmd_i.goal_load) begin
        gx_q <= goal_x_i;
        gy_q <= goal_y_i;
      end
      if (cmd_i.target_latch) begin
        bearing_q <= bearing_d;
        heading_q <= heading_d;
      end
      if (cmd_i.prev_update) prev_q <= dist_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.goal_load) hprod_q <= HW'(goal_heading_deg_i) * DEG_K;
    if (cmd_i.cordic_init) begin
      cx_q   <= x0;
      cy_q   <= y0;
      cz_q   <= z0;
      cnt_q  <= '0;
      zero_q <= (dx == '0) && (dy == '0);
    end else if (cmd_i.cordic_step) begin
      if (y_pos) begin
        cx_q <= cx_q + ys;
        cy_q <= cy_q - xs;
        cz_q <= cz_q + at;
      end else begin
        cx_q <= cx_q - ys;
        cy_q <= cy_q + xs;
        cz_q <= cz_q - at;
      end
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.dist_load) begin
      a_q   <= adx;
      b_q   <= ady;
      sat_q <= (adx > DMAX_N) || (ady > DMAX_N);
      sh_q  <= '0;
    end else if (cmd_i.dist_norm) begin
      a_q  <= a_q >> 1;
      b_q  <= b_q >> 1;
      sh_q <= sh_q + 1'b1;
    end
    if (cmd_i.dist_sq_a) sqa_q <= sqa_d;
    if (cmd_i.dist_sq_b) begin
      v_q   <= RAD_W'(sqa_q) + RAD_W'(sqb_d);
      r_q   <= '0;
      bit_q <= RAD_W'(1) << (RAD_W - 2);
    end else if (cmd_i.sqrt_step) begin
      if (v_q >= trial) begin
        v_q <= v_q - trial;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (cmd_i.dist_final) dist_q <= (sat_q || rx > DMAX_R) ? {DW{1'b1}} : DW'(rx);
    if (cmd_i.emit) begin
      last_q <= cmd_i.res_last;
      case (cmd_i.res_sel)
        RES_TURN: begin
          ang_q <= ANGLE_WIDTH'(db);
          lin_q <= '0;
          fin_q <= 1'b0;
        end
        RES_CRUISE: begin
          ang_q <= '0;
          lin_q <= DW'(cruise_q);
          fin_q <= 1'b0;
        end
        RES_DIST: begin
          ang_q <= '0;
          lin_q <= dist_q;
          fin_q <= 1'b0;
        end
        RES_HEAD: begin
          ang_q <= ANGLE_WIDTH'(dh);
          lin_q <= '0;
          fin_q <= 1'b0;
        end
        RES_DONE: begin
          ang_q <= '0;
          lin_q <= '0;
          fin_q <= 1'b1;
        end
        default: begin
          ang_q <= '0;
          lin_q <= '0;
          fin_q <= 1'b0;
        end
      endcase
    end
  end

  assign angular_rate_o    = ang_q;
  assign linear_speed_o    = lin_q;
  assign last_of_run_o     = last_q;
  assign motion_finished_o = fin_q;

endmodule

FILE: design/pss_ctrl.sv
// ----------------------------------------------------------------------------
// pss_ctrl
// controller: phase tracking, computation sequencing and command issue
// ----------------------------------------------------------------------------
`include "point_and_shoot_steering_unit_assert.svh"

module pss_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_kind_i,
  output logic             in_ready_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  input  pss_pkg::status_t sts_i,
  output pss_pkg::cmd_t    cmd_o
);
  import pss_pkg::*;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_TURN  = 2'd1;
  localparam logic [1:0] PH_DRIVE = 2'd2;
  localparam logic [1:0] PH_FINAL = 2'd3;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CPRE    = 4'd1;
  localparam logic [3:0] S_CITER   = 4'd2;
  localparam logic [3:0] S_CEND    = 4'd3;
  localparam logic [3:0] S_ETURN   = 4'd4;
  localparam logic [3:0] S_ECRUISE = 4'd5;
  localparam logic [3:0] S_DLOAD   = 4'd6;
  localparam logic [3:0] S_DNORM   = 4'd7;
  localparam logic [3:0] S_DSQA    = 4'd8;
  localparam logic [3:0] S_DSQB    = 4'd9;
  localparam logic [3:0] S_DSQRT   = 4'd10;
  localparam logic [3:0] S_DFIN    = 4'd11;
  localparam logic [3:0] S_EDIST   = 4'd12;
  localparam logic [3:0] S_ESTOP   = 4'd13;
  localparam logic [3:0] S_EHEAD   = 4'd14;
  localparam logic [3:0] S_EDONE   = 4'd15;

  logic [3:0] state_q, state_d;
  logic [1:0] phase_q, phase_d;
  logic       ft_q, ft_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free, accept;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = state_q == S_IDLE;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    phase_d = phase_q;
    ft_d    = ft_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_kind_i) begin
            if (phase_q == PH_IDLE) begin
              cmd_o.goal_load = 1'b1;
              state_d = S_CPRE;
            end
          end else begin
            cmd_o.in_capture = 1'b1;
            case (phase_q)
              PH_TURN:  state_d = S_ETURN;
              PH_DRIVE: state_d = S_DLOAD;
              PH_FINAL: state_d = S_EHEAD;
              default:  state_d = S_IDLE;
            endcase
          end
        end
      end
      S_CPRE: begin
        cmd_o.cordic_init = 1'b1;
        state_d = S_CITER;
      end
      S_CITER: begin
        cmd_o.cordic_step = 1'b1;
        if (sts_i.cordic_last) state_d = S_CEND;
      end
      S_CEND: begin
        cmd_o.target_latch = 1'b1;
        phase_d = PH_TURN;
        state_d = S_IDLE;
      end
      S_ETURN: begin
        cmd_o.res_sel  = RES_TURN;
        cmd_o.res_last = !sts_i.turn_ok;
        if (out_free) begin
          cmd_o.emit = 1'b1;
          state_d = sts_i.turn_ok ? S_ECRUISE : S_IDLE;
        end
      end
      S_ECRUISE: begin
        cmd_o.res_sel = RES_CRUISE;
        if (out_free) begin
          cmd_o.emit = 1'b1;
          phase_d = PH_DRIVE;
          ft_d    = 1'b1;
          state_d = S_DLOAD;
        end
      end
      S_DLOAD: begin
        cmd_o.dist_load = 1'b1;
        state_d = S_DNORM;
      end
      S_DNORM: begin
        if (sts_i.norm_done) state_d = S_DSQA;
        else cmd_o.dist_norm = 1'b1;
      end
      S_DSQA: begin
        cmd_o.dist_sq_a = 1'b1;
        state_d = S_DSQB;
      end
      S_DSQB: begin
        cmd_o.dist_sq_b = 1'b1;
        state_d = S_DSQRT;
      end
      S_DSQRT: begin
        if (sts_i.sqrt_done) state_d = S_DFIN;
        else cmd_o.sqrt_step = 1'b1;
      end
      S_DFIN: begin
        cmd_o.dist_final = 1'b1;
        state_d = S_EDIST;
      end
      S_EDIST: begin
        cmd_o.cmp_margin = ft_q;
        cmd_o.res_sel    = RES_DIST;
        cmd_o.res_last   = !sts_i.grew;
        if (out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.prev_update = 1'b1;
          ft_d    = 1'b0;
          state_d = sts_i.grew ? S_ESTOP : S_IDLE;
        end
      end
      S_ESTOP: begin
        cmd_o.res_sel = RES_STOP;
        if (out_free) begin
          cmd_o.emit = 1'b1;
          phase_d = PH_FINAL;
          state_d = S_EHEAD;
        end
      end
      S_EHEAD: begin
        cmd_o.res_sel  = RES_HEAD;
        cmd_o.res_last = !sts_i.final_ok;
        if (out_free) begin
          cmd_o.emit = 1'b1;
          state_d = sts_i.final_ok ? S_EDONE : S_IDLE;
        end
      end
      S_EDONE: begin
        cmd_o.res_sel  = RES_DONE;
        cmd_o.res_last = 1'b1;
        if (out_free) begin
          cmd_o.emit = 1'b1;
          phase_d = PH_IDLE;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_IDLE;
      ft_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      ft_q        <= ft_d;
      out_valid_q <= out_valid_d;
    end
  end

  `PSS_ASSERT_SAME(a_emit_free, clk_i, rst_ni, cmd_o.emit, !out_valid_q || out_ready_i)
  `PSS_ASSERT_SAME(a_done_last, clk_i, rst_ni, cmd_o.emit && cmd_o.res_sel == RES_DONE, cmd_o.res_last)
  `PSS_ASSERT_NEXT(a_done_idle, clk_i, rst_ni, cmd_o.emit && cmd_o.res_sel == RES_DONE, phase_q == PH_IDLE && state_q == S_IDLE)
  `PSS_ASSERT_NEXT(a_target_turn, clk_i, rst_ni, state_q == S_CEND, phase_q == PH_TURN)

endmodule

FILE: design/point_and_shoot_steering_unit.sv
// ----------------------------------------------------------------------------
// point_and_shoot_steering_unit
// three-phase go-to-goal controller: turn to bearing, drive, turn to heading
//
// channel   dir  contents
// in_ch_i   in   kind, pos_x, pos_y, yaw, goal_x, goal_y, goal_heading_deg
// out_ch_o  out  angular_rate, linear_speed, last_of_run, motion_finished
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i
//
// goal request: bearing computed by the iterative cordic unit
// odometry request in drive: normalize, squaring and the bit-pair square root,
// then the commands
// turn phases: commands come straight from the latched angles; one request in flight at a time
// results wait in an output register; a stalled sink holds the sequence
// async active-low reset restores idle phase and config defaults
// ----------------------------------------------------------------------------
module point_and_shoot_steering_unit #(
  parameter int POS_WIDTH    = pss_pkg::POS_WIDTH_DEF,
  parameter int ANGLE_WIDTH  = pss_pkg::ANGLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = pss_pkg::CORDIC_STEPS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pss_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pss_pkg::CFG_DATA_W-1:0] cfg_data_i,
  pss_in_if.sink                         in_ch_i,
  pss_out_if.source                      out_ch_o
);
  import pss_pkg::*;

  cmd_t    cmd;
  status_t sts;

  pss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch_i.valid),
    .in_kind_i   (in_ch_i.kind),
    .in_ready_o  (in_ch_i.ready),
    .out_ready_i (out_ch_o.ready),
    .out_valid_o (out_ch_o.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pss_dp #(
    .POS_WIDTH    (POS_WIDTH),
    .ANGLE_WIDTH  (ANGLE_WIDTH),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .pos_x_i            (in_ch_i.pos_x),
    .pos_y_i            (in_ch_i.pos_y),
    .yaw_i              (in_ch_i.yaw),
    .goal_x_i           (in_ch_i.goal_x),
    .goal_y_i           (in_ch_i.goal_y),
    .goal_heading_deg_i (in_ch_i.goal_heading_deg),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .angular_rate_o     (out_ch_o.angular_rate),
    .linear_speed_o     (out_ch_o.linear_speed),
    .last_of_run_o      (out_ch_o.last_of_run),
    .motion_finished_o  (out_ch_o.motion_finished)
  );

endmodule

FILE: tb/steering_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// steering_checker
// Watches the configuration port and both channels of the steering unit.
// Every accepted request runs through a local model of the three-phase
// controller; the twist commands it predicts are queued in order and each
// command leaving the unit is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module steering_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pss_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pss_pkg::CFG_DATA_W-1:0] cfg_data_i,
  pss_in_if                              in_ch,
  pss_out_if                             out_ch,
  output int                             fail_cnt_o,
  output int                             pending_o,
  output int                             requests_o,
  output int                             commands_o,
  output int                             goals_o,
  output int                             arrivals_o
);
  import pss_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_TURN, PH_DRIVE, PH_FINAL} phase_e;

  typedef struct {
    logic signed [15:0] ang;
    logic [30:0]        lin;
    logic               last;
    logic               fin;
  } twist_t;

  localparam longint HALF_TURN = (longint'(PI_Q20) + 128) >>> 8;
  localparam longint SPEED_MAX = 64'h7fff_ffff;
  localparam longint ARCTAN [7] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383};

  twist_t     twist_q[$];
  phase_e     phase;
  longint     bearing, heading, goal_x, goal_y, prev_dist, at_x, at_y, at_yaw;
  longint     align_tol, final_tol, cruise, margin;

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint wrap_pi(longint a);
    while (a > HALF_TURN) a -= 2 * HALF_TURN;
    while (a < -HALF_TURN) a += 2 * HALF_TURN;
    return a;
  endfunction

  function automatic longint bearing_to(longint dx, longint dy);
    longint x, y, z, t, xs, ys, step;
    x = dx;
    y = dy;
    z = 0;
    if (dx == 0 && dy == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = HALF_PI_Q20;
      end else begin
        x = -y; y = t; z = -HALF_PI_Q20;
      end
    end
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      step = (i < 7) ? ARCTAN[i] : (longint'(1) << (ATAN_FRAC - i));
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += step;
      end else begin
        x -= ys; y += xs; z -= step;
      end
    end
    return wrap_pi(rnd_shift(z, ATAN_FRAC - 12));
  endfunction

  function automatic longint root_floor(longint unsigned v);
    longint unsigned r, bit_v;
    r = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= r + bit_v) begin
        v -= r + bit_v;
        r = (r >> 1) + bit_v;
      end else begin
        r >>= 1;
      end
      bit_v >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint range_to_goal();
    longint a, b, r;
    a = goal_x - at_x;
    b = goal_y - at_y;
    if (a < 0) a = -a;
    if (b < 0) b = -b;
    if (a > SPEED_MAX || b > SPEED_MAX) return SPEED_MAX;
    r = root_floor(a * a + b * b);
    return (r > SPEED_MAX) ? SPEED_MAX : r;
  endfunction

  task automatic add_twist(longint ang, longint lin, bit fin);
    twist_t t;
    t.ang  = ang[15:0];
    t.lin  = lin[30:0];
    t.last = 1'b0;
    t.fin  = fin;
    twist_q.push_back(t);
  endtask

  task automatic steer_step();
    longint delta, d;
    int     base;
    bit     grew;
    base = twist_q.size();
    if (in_ch.kind) begin
      if (phase == PH_IDLE) begin
        goal_x  = longint'(in_ch.goal_x);
        goal_y  = longint'(in_ch.goal_y);
        bearing = bearing_to(goal_x - at_x, goal_y - at_y);
        heading = wrap_pi(rnd_shift(longint'(in_ch.goal_heading_deg) * DEG_RAD_Q28,
                                    DEG_FRAC - 12));
        phase   = PH_TURN;
        goals_o++;
      end
      return;
    end
    at_x   = longint'(in_ch.pos_x);
    at_y   = longint'(in_ch.pos_y);
    at_yaw = longint'(in_ch.yaw);
    if (phase == PH_TURN) begin
      delta = bearing - wrap_pi(at_yaw);
      add_twist(delta, 0, 0);
      if ((delta < 0 ? -delta : delta) <= align_tol) begin
        add_twist(0, cruise, 0);
        prev_dist = range_to_goal() + margin;
        phase = PH_DRIVE;
      end
    end
    if (phase == PH_DRIVE) begin
      d = range_to_goal();
      grew = d > prev_dist;
      prev_dist = d;
      add_twist(0, d, 0);
      if (grew) begin
        add_twist(0, 0, 0);
        phase = PH_FINAL;
      end
    end
    if (phase == PH_FINAL) begin
      delta = heading - wrap_pi(at_yaw);
      add_twist(delta, 0, 0);
      if ((delta < 0 ? -delta : delta) <= final_tol) begin
        add_twist(0, 0, 1);
        phase = PH_IDLE;
        arrivals_o++;
      end
    end
    if (twist_q.size() > base) twist_q[$].last = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    twist_t want;
    if (!rst_ni) begin
      twist_q.delete();
      phase = PH_IDLE;
      bearing = 0; heading = 0; goal_x = 0; goal_y = 0; prev_dist = 0;
      at_x = 0; at_y = 0; at_yaw = 0;
      align_tol = ALIGN_TOL_RST; final_tol = FINAL_TOL_RST;
      cruise = CRUISE_RST; margin = MARGIN_RST;
      fail_cnt_o = 0; requests_o = 0; commands_o = 0; goals_o = 0; arrivals_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ALIGN_TOL: align_tol = cfg_data_i[TOL_W-1:0];
          REG_FINAL_TOL: final_tol = cfg_data_i[TOL_W-1:0];
          REG_CRUISE:    cruise = cfg_data_i[SPEED_W-1:0];
          REG_MARGIN:    margin = cfg_data_i[SPEED_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        requests_o++;
        steer_step();
      end
      if (out_ch.valid && out_ch.ready) begin
        commands_o++;
        if (twist_q.size() == 0) begin
          $error("unexpected twist command: ang %0d lin %0d", out_ch.angular_rate,
                 out_ch.linear_speed);
          fail_cnt_o++;
        end else begin
          want = twist_q.pop_front();
          if (out_ch.angular_rate !== want.ang) begin
            $error("angular_rate: expected %0d, got %0d", want.ang, out_ch.angular_rate);
            fail_cnt_o++;
          end
          if (out_ch.linear_speed !== want.lin) begin
            $error("linear_speed: expected %0d, got %0d", want.lin, out_ch.linear_speed);
            fail_cnt_o++;
          end
          if (out_ch.last_of_run !== want.last) begin
            $error("last_of_run: expected %0b, got %0b", want.last, out_ch.last_of_run);
            fail_cnt_o++;
          end
          if (out_ch.motion_finished !== want.fin) begin
            $error("motion_finished: expected %0b, got %0b", want.fin,
                   out_ch.motion_finished);
            fail_cnt_o++;
          end
        end
      end
    end
    pending_o = twist_q.size();
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives the steering unit with whole go-to-goal trips (start pose, goal,
// turn, drive with a retreat past the goal, final turn) under several
// register settings, plus idle odometry noise and goals sent while busy.
// Both channels stall at random; the checker beside the unit does the scoring.
// ----------------------------------------------------------------------------
module tb;
  import pss_pkg::*;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  pss_in_if  in_ch ();
  pss_out_if out_ch ();

  int fail_cnt, pending, requests, commands, goals, arrivals;
  int sent_cnt;
  int stall_cnt;
  bit quiet;
  bit held;

  point_and_shoot_steering_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch_i    (in_ch),
    .out_ch_o   (out_ch)
  );

  steering_checker checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending),
    .requests_o (requests),
    .commands_o (commands),
    .goals_o    (goals),
    .arrivals_o (arrivals)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // sink side: random stalls, one long hold-off
  always @(posedge clk_i) begin
    if (!held && sent_cnt >= 80) begin
      held = 1'b1;
      out_ch.ready <= 1'b0;
      repeat (400) @(posedge clk_i);
    end else begin
      out_ch.ready <= quiet || ($urandom_range(0, 99) >= 24);
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= 20000) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic put(bit kind, longint px, longint py, longint yaw,
                     longint gx, longint gy, int hd);
    while (!quiet && $urandom_range(0, 99) < 24) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid            <= 1'b1;
    in_ch.kind             <= kind;
    in_ch.pos_x            <= px[31:0];
    in_ch.pos_y            <= py[31:0];
    in_ch.yaw              <= yaw[15:0];
    in_ch.goal_x           <= gx[31:0];
    in_ch.goal_y           <= gy[31:0];
    in_ch.goal_heading_deg <= hd[10:0];
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sent_cnt++;
    quiet = (sent_cnt >= 140 && sent_cnt < 180);
  endtask

  task automatic odo(longint px, longint py, longint yaw);
    put(1'b0, px, py, yaw, $urandom, $urandom, $urandom_range(0, 2047));
  endtask

  task automatic goal(longint gx, longint gy, int hd);
    put(1'b1, $urandom, $urandom, $urandom_range(0, 65535), gx, gy, hd);
  endtask

  // yaw pointing from p to g, sometimes one full turn away
  function automatic longint aim(longint px, longint py, longint gx, longint gy);
    real    a;
    longint q;
    a = $atan2(real'(gy - py), real'(gx - px));
    q = $rtoi(a * 4096.0 + (a >= 0.0 ? 0.5 : -0.5));
    if ($urandom_range(0, 3) == 0) q += (q > 0) ? -25736 : 25736;
    return q;
  endfunction

  function automatic longint head_yaw(int hd);
    longint h;
    h = (longint'(hd) * DEG_RAD_Q28 + (longint'(1) << 15)) >>> 16;
    while (h > 12868) h -= 25736;
    while (h < -12868) h += 25736;
    return h;
  endfunction

  function automatic longint rand_pos();
    if ($urandom_range(0, 9) == 0) return longint'($signed($urandom));
    return longint'($signed($urandom) >>> 8);
  endfunction

  task automatic trip(longint px, longint py, longint gx, longint gy, int hd,
                      int steps, int twists);
    longint rx, ry, yaw_aim;
    yaw_aim = aim(px, py, gx, gy);
    rx = gx + ((gx > 0) ? -64'd65536000 : 64'd65536000);
    ry = gy + ((gy > 0) ? -64'd3276800 : 64'd3276800);
    odo(px, py, $urandom_range(0, 65535));
    goal(gx, gy, hd);
    goal(rand_pos(), rand_pos(), $urandom_range(0, 2047));
    repeat (twists) odo(px, py, $urandom_range(0, 65535));
    odo(px, py, yaw_aim);
    for (int i = 1; i <= steps; i++)
      odo(px + (gx - px) * i / steps, py + (gy - py) * i / steps, yaw_aim);
    odo(rx, ry, yaw_aim);
    repeat (twists) odo(rx, ry, $urandom_range(0, 65535));
    odo(rx, ry, head_yaw(hd) + (($urandom_range(0, 1) == 1) ? 25736 : 0) *
                (head_yaw(hd) < 0 ? 1 : -1));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic configure(int unsigned atol, int unsigned ftol, int unsigned spd,
                           int unsigned mrg);
    logic [CFG_IDX_W-1:0] idx [4];
    int unsigned          val [4];
    idx = '{REG_ALIGN_TOL, REG_FINAL_TOL, REG_CRUISE, REG_MARGIN};
    val = '{atol, ftol, spd, mrg};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[i];
      cfg_data_i <= val[i][CFG_DATA_W-1:0];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_trips(int until_cnt, bit same_spot);
    longint px, py;
    while (sent_cnt < until_cnt) begin
      repeat ($urandom_range(0, 2)) odo(rand_pos(), rand_pos(), $urandom_range(0, 65535));
      px = rand_pos();
      py = rand_pos();
      if (same_spot) trip(px, py, px, py, $urandom_range(0, 2047) - 1024, 1, 1);
      else trip(px, py, rand_pos(), rand_pos(), $urandom_range(0, 2047) - 1024,
                $urandom_range(1, 5), $urandom_range(0, 2));
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = '0;
    cfg_data_i       = '0;
    in_ch.valid      = 1'b0;
    in_ch.kind       = 1'b0;
    in_ch.pos_x      = '0;
    in_ch.pos_y      = '0;
    in_ch.yaw        = '0;
    in_ch.goal_x     = '0;
    in_ch.goal_y     = '0;
    in_ch.goal_heading_deg = '0;
    out_ch.ready     = 1'b0;
    sent_cnt         = 0;
    quiet            = 1'b0;
    held             = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset register values
    odo(64'sh7fff_ffff, -64'sh8000_0000, -32768);
    trip(-64'sh8000_0000, -64'sh8000_0000, 64'sh7fff_ffff, 64'sh7fff_ffff, 720, 2, 1);
    trip(64'sh0001_0000, -64'sh0002_0000, 64'sh0001_0000, -64'sh0002_0000, -720, 1, 0);
    trip(0, 0, -64'sh0003_0000, 64'sh0000_8000, 1023, 1, 0);
    trip(0, 0, -64'sh0000_4000, -64'sh0005_0000, -1024, 1, 0);
    drain();

    configure(20, 41, 655360, 65536);
    random_trips(90, 1'b0);
    drain();
    configure(0, 0, 0, 0);
    random_trips(sent_cnt + 20, 1'b1);
    drain();
    configure(4095, 4095, 32'h7fff_ffff, 32'h7fff_ffff);
    random_trips(sent_cnt + 30, 1'b0);
    drain();
    configure($urandom_range(8, 300), $urandom_range(0, 4095), $urandom_range(0, 32'h7fff_ffff),
              $urandom_range(0, 32'h0100_0000));
    random_trips(215, 1'b0);
    drain();

    $display("covered %0d requests, %0d twist commands checked", requests, commands);
    $display("%0d goals latched, %0d trips finished, 4 register settings", goals, arrivals);
    if (fail_cnt == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/pss_pkg.sv
design/pss_if.sv
design/pss_dp.sv
design/pss_ctrl.sv
design/point_and_shoot_steering_unit.sv
tb/steering_checker.sv
tb/tb.sv
